// File: rtl/core/mdb_pkg.sv
// shared types and constants of the multidrop register bus node
// no dependencies; imported by mdb_ctrl, mdb_dp, the top level and the testbench
package mdb_pkg;

  // input item codes
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_NODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  ACK_OK      = 8'hFF;
  localparam logic [7:0]  ACK_BAD     = 8'h00;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SKIP_SUM  = 4'd1,
    PH_OWN_SUM   = 4'd2,
    PH_SKIP_LEN  = 4'd3,
    PH_OWN_LEN   = 4'd4,
    PH_SKIP_BODY = 4'd5,
    PH_COMMAND   = 4'd6,
    PH_CHAR_DATA = 4'd7,
    PH_INT_LOW   = 4'd8,
    PH_INT_HIGH  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_DECODE = 3'd2,
    ST_GATHER = 3'd3,
    ST_COPY   = 3'd4,
    ST_COMMIT = 3'd5,
    ST_EMIT   = 3'd6
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic gather;
    logic clear;
    logic copy;
    logic commit;
    logic emit_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic copy_req;
    logic commit_req;
    logic clr_done;
    logic mv_done;
    logic last_beat;
  } dp_stat_t;

endpackage

// File: rtl/core/mdb_in_if.sv
// input channel of the bus node: valid/ready plus one input item
// depends on nothing
interface mdb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         rx_byte;
  logic               local_is_int;
  logic [5:0]         local_index;
  logic signed [15:0] local_value;

  modport source (output valid, cmd, rx_byte, local_is_int, local_index, local_value,
                  input ready);
  modport sink   (input valid, cmd, rx_byte, local_is_int, local_index, local_value,
                  output ready);
endinterface

// File: rtl/core/mdb_out_if.sv
// result channel of the bus node: valid/ready plus one result item
// depends on nothing
interface mdb_out_if;
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic               last;
  logic               cycle_event;
  logic               ready_event;
  logic               error_event;
  logic               complete_event;
  logic signed [15:0] read_value;
  logic               read_changed;

  modport source (output valid, tx_valid, tx_byte, last, cycle_event, ready_event,
                  error_event, complete_event, read_value, read_changed,
                  input ready);
  modport sink   (input valid, tx_valid, tx_byte, last, cycle_event, ready_event,
                  error_event, complete_event, read_value, read_changed,
                  output ready);
endinterface

// File: rtl/core/mdb_ctrl.sv
// sequencer of the bus node: steps each item through decode, gather,
// register sweeps and result beats; uses mdb_pkg
module mdb_ctrl
  import mdb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (stat.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = ST_GATHER;
      ST_GATHER: begin
        priority if (stat.copy_req) state_nxt = ST_COPY;
        else if (stat.commit_req)   state_nxt = ST_COMMIT;
        else                        state_nxt = ST_EMIT;
      end
      ST_COPY:   if (stat.mv_done) state_nxt = ST_EMIT;
      ST_COMMIT: if (stat.mv_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_ready && stat.last_beat) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: cmd.decode = 1'b1;
      ST_GATHER: cmd.gather = 1'b1;
      ST_COPY:   cmd.copy   = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.emit_adv = out_ready;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/mdb_dp.sv
// datapath of the bus node: frame parser registers, live and shadow
// register memories, changed marks, reply buffer; uses mdb_pkg
module mdb_dp
  import mdb_pkg::*;
#(
  parameter int unsigned CHAR_REGS = 32,
  parameter int unsigned INT_REGS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_local_is_int,
  input  logic [5:0]           in_local_index,
  input  logic [15:0]          in_local_value,
  output logic                 out_tx_valid,
  output logic [7:0]           out_tx_byte,
  output logic                 out_last,
  output logic                 out_cycle_event,
  output logic                 out_ready_event,
  output logic                 out_error_event,
  output logic                 out_complete_event,
  output logic [15:0]          out_read_value,
  output logic                 out_read_changed
);

  localparam int unsigned MAXR = (CHAR_REGS > INT_REGS) ? CHAR_REGS : INT_REGS;
  localparam int unsigned SWW  = $clog2(MAXR + 1);
  localparam int unsigned CIW  = (CHAR_REGS > 1) ? $clog2(CHAR_REGS) : 1;
  localparam int unsigned IIW  = (INT_REGS > 1) ? $clog2(INT_REGS) : 1;
  localparam logic [6:0]  CHAR_N = 7'(CHAR_REGS);
  localparam logic [6:0]  INT_N  = 7'(INT_REGS);
  localparam logic [SWW-1:0] SW_CLR_END = SWW'(MAXR - 1);
  localparam logic [SWW-1:0] SW_MV_END  = SWW'(MAXR);

  // configuration
  logic [7:0]  node_r;
  logic [15:0] tout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= '0;
      tout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE:    node_r <= cfg_wdata[7:0];
        REG_TIMEOUT: tout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]  icmd_r;
  logic [7:0]  rx_r;
  logic        isint_r;
  logic [5:0]  lidx_r;
  logic [15:0] lval_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      icmd_r  <= in_cmd;
      rx_r    <= in_rx_byte;
      isint_r <= in_local_is_int;
      lidx_r  <= in_local_index;
      lval_r  <= in_local_value;
    end
  end

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  rem_r, rem_nxt, sum_r, sum_nxt, ccmd_r, ccmd_nxt, low_r, low_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        err_r, err_nxt, sess_r, sess_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [CHAR_REGS-1:0] clc_r, clc_nxt, csc_r, csc_nxt;
  logic [INT_REGS-1:0]  ilc_r, ilc_nxt, isc_r, isc_nxt;

  // per-item flags
  logic rd_r, rd_nxt, ack_r, ack_nxt, copy_r, copy_nxt, commit_r, commit_nxt;
  logic evc_r, evc_nxt, evr_r, evr_nxt, eve_r, eve_nxt, rchg_r, rchg_nxt;
  logic [7:0] ackb_r, ackb_nxt;
  logic cw_en, iw_en, done;
  logic [5:0]  ci;
  logic        c_in, i_in, l_cin, l_iin;
  logic [16:0] tick_sum;

  assign ci    = ccmd_r[5:0];
  assign c_in  = {1'b0, ci} < CHAR_N;
  assign i_in  = {1'b0, ci} < INT_N;
  assign l_cin = {1'b0, lidx_r} < CHAR_N;
  assign l_iin = {1'b0, lidx_r} < INT_N;
  assign tick_sum = {1'b0, idle_r} + 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    ccmd_nxt  = ccmd_r;
    low_nxt   = low_r;
    prev_nxt  = prev_r;
    err_nxt   = err_r;
    sess_nxt  = sess_r;
    idle_nxt  = idle_r;
    clc_nxt   = clc_r;
    csc_nxt   = csc_r;
    ilc_nxt   = ilc_r;
    isc_nxt   = isc_r;
    rd_nxt = 1'b0; ack_nxt = 1'b0; copy_nxt = 1'b0; commit_nxt = 1'b0;
    evc_nxt = 1'b0; evr_nxt = 1'b0; eve_nxt = 1'b0; rchg_nxt = 1'b0;
    ackb_nxt = ACK_OK;
    cw_en = 1'b0; iw_en = 1'b0; done = 1'b0;

    unique case (icmd_r)
      CMD_BYTE: begin
        idle_nxt = '0;
        unique case (phase_r)
          PH_IDLE: begin
            if (!sess_r) err_nxt = 1'b0;
            evc_nxt  = (prev_r >= rx_r);
            prev_nxt = rx_r;
            if (rx_r == node_r) begin
              evr_nxt   = 1'b1;
              copy_nxt  = 1'b1;
              phase_nxt = PH_OWN_SUM;
            end else begin
              phase_nxt = PH_SKIP_SUM;
            end
          end
          PH_SKIP_SUM: phase_nxt = PH_SKIP_LEN;
          PH_OWN_SUM: begin
            sum_nxt   = rx_r + node_r;
            phase_nxt = PH_OWN_LEN;
          end
          PH_SKIP_LEN: begin
            rem_nxt   = rx_r;
            phase_nxt = (rx_r == 8'd0) ? PH_IDLE : PH_SKIP_BODY;
          end
          PH_OWN_LEN: begin
            rem_nxt = rx_r;
            sum_nxt = sum_r + rx_r;
            if (rx_r == 8'd0) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_COMMAND;
              sess_nxt  = 1'b1;
            end
          end
          PH_SKIP_BODY: begin
            rem_nxt = rem_r - 8'd1;
            if (rem_nxt == 8'd0) phase_nxt = PH_IDLE;
          end
          PH_COMMAND: begin
            ccmd_nxt = rx_r;
            rem_nxt  = rem_r - 8'd1;
            sum_nxt  = sum_r + rx_r;
            priority if (rx_r[7]) begin
              rd_nxt = 1'b1;
              if (rem_nxt == 8'd0) begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end
            end else if (rem_nxt == 8'd0) begin
              err_nxt   = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = rx_r[6] ? PH_INT_LOW : PH_CHAR_DATA;
            end
          end
          PH_CHAR_DATA: begin
            if (c_in) begin
              cw_en   = 1'b1;
              csc_nxt[ci[CIW-1:0]] = 1'b1;
              sum_nxt = sum_r + rx_r;
            end else begin
              err_nxt = 1'b1;
            end
            rem_nxt = rem_r - 8'd1;
            if (rem_nxt == 8'd0) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_COMMAND;
            end
          end
          PH_INT_LOW: begin
            if (rem_r <= 8'd1) begin
              rem_nxt   = '0;
              err_nxt   = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              low_nxt = rx_r;
              if (i_in) sum_nxt = sum_r + rx_r;
              rem_nxt   = rem_r - 8'd1;
              phase_nxt = PH_INT_HIGH;
            end
          end
          PH_INT_HIGH: begin
            if (i_in) begin
              sum_nxt = sum_r + rx_r;
              iw_en   = 1'b1;
              isc_nxt[ci[IIW-1:0]] = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
            rem_nxt = rem_r - 8'd1;
            if (rem_nxt == 8'd0) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_COMMAND;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
        if (sess_nxt && phase_nxt == PH_IDLE) begin
          ack_nxt  = 1'b1;
          sess_nxt = 1'b0;
          if (!(sum_nxt == 8'd0 && !err_nxt)) begin
            ackb_nxt = ACK_BAD;
            eve_nxt  = 1'b1;
          end
        end
        if (done && sum_nxt == 8'd0) begin
          commit_nxt = 1'b1;
          clc_nxt    = csc_nxt;
          ilc_nxt    = isc_nxt;
        end
      end
      CMD_TICK: begin
        if (tick_sum > {1'b0, tout_r}) begin
          phase_nxt = PH_IDLE;
          if (sess_r) begin
            ack_nxt  = 1'b1;
            sess_nxt = 1'b0;
            if (!(sum_r == 8'd0 && !err_r)) begin
              ackb_nxt = ACK_BAD;
              eve_nxt  = 1'b1;
            end
          end
        end
        idle_nxt = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
      end
      CMD_WRITE: ;
      CMD_READ: begin
        if (isint_r) begin
          if (l_iin) begin
            rchg_nxt = ilc_r[lidx_r[IIW-1:0]];
            ilc_nxt[lidx_r[IIW-1:0]] = 1'b0;
          end
        end else if (l_cin) begin
          rchg_nxt = clc_r[lidx_r[CIW-1:0]];
          clc_nxt[lidx_r[CIW-1:0]] = 1'b0;
        end
      end
      default: ;
    endcase
    if (copy_nxt) begin
      csc_nxt = clc_r;
      isc_nxt = ilc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rem_r   <= '0;
      sum_r   <= '0;
      ccmd_r  <= '0;
      low_r   <= '0;
      prev_r  <= '0;
      err_r   <= 1'b0;
      sess_r  <= 1'b0;
      idle_r  <= '0;
      clc_r   <= '0;
      csc_r   <= '0;
      ilc_r   <= '0;
      isc_r   <= '0;
      copy_r   <= 1'b0;
      commit_r <= 1'b0;
    end else if (cmd.decode) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      sum_r   <= sum_nxt;
      ccmd_r  <= ccmd_nxt;
      low_r   <= low_nxt;
      prev_r  <= prev_nxt;
      err_r   <= err_nxt;
      sess_r  <= sess_nxt;
      idle_r  <= idle_nxt;
      clc_r   <= clc_nxt;
      csc_r   <= csc_nxt;
      ilc_r   <= ilc_nxt;
      isc_r   <= isc_nxt;
      copy_r   <= copy_nxt;
      commit_r <= commit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      rd_r   <= rd_nxt;
      ack_r  <= ack_nxt;
      ackb_r <= ackb_nxt;
      evc_r  <= evc_nxt;
      evr_r  <= evr_nxt;
      eve_r  <= eve_nxt;
      rchg_r <= rchg_nxt;
    end
  end

  // sweep counter for clear, copy and commit passes
  logic [SWW-1:0] swp_r, swm1;
  logic           sweeping;
  assign sweeping = cmd.clear || cmd.copy || cmd.commit;
  assign swm1     = swp_r - SWW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_r <= '0;
    end else begin
      swp_r <= sweeping ? swp_r + SWW'(1) : '0;
    end
  end

  logic sw_wr;
  assign sw_wr = (swp_r != '0);

  // register memories
  logic [7:0]  cl_mem [CHAR_REGS];
  logic [7:0]  cs_mem [CHAR_REGS];
  logic [15:0] il_mem [INT_REGS];
  logic [15:0] is_mem [INT_REGS];
  logic [7:0]  cl_rd, cs_rd;
  logic [15:0] il_rd, is_rd;
  logic [5:0]  dec_addr;
  logic [6:0]  ra_l, ra_s;

  assign dec_addr = (icmd_r == CMD_READ) ? lidx_r : rx_r[5:0];
  assign ra_l     = cmd.copy ? 7'(swp_r) : {1'b0, dec_addr};
  assign ra_s     = 7'(swp_r);

  always_ff @(posedge clk) begin
    if (cmd.clear && 7'(swp_r) < CHAR_N) begin
      cl_mem[swp_r[CIW-1:0]] <= '0;
    end else if (cmd.commit && sw_wr && 7'(swm1) < CHAR_N) begin
      cl_mem[swm1[CIW-1:0]] <= cs_rd;
    end else if (cmd.decode && icmd_r == CMD_WRITE && !isint_r && l_cin) begin
      cl_mem[lidx_r[CIW-1:0]] <= lval_r[7:0];
    end
    cl_rd <= cl_mem[ra_l[CIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && 7'(swp_r) < INT_N) begin
      il_mem[swp_r[IIW-1:0]] <= '0;
    end else if (cmd.commit && sw_wr && 7'(swm1) < INT_N) begin
      il_mem[swm1[IIW-1:0]] <= is_rd;
    end else if (cmd.decode && icmd_r == CMD_WRITE && isint_r && l_iin) begin
      il_mem[lidx_r[IIW-1:0]] <= lval_r;
    end
    il_rd <= il_mem[ra_l[IIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy && sw_wr && 7'(swm1) < CHAR_N) begin
      cs_mem[swm1[CIW-1:0]] <= cl_rd;
    end else if (cmd.decode && cw_en) begin
      cs_mem[ci[CIW-1:0]] <= rx_r;
    end
    cs_rd <= cs_mem[ra_s[CIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy && sw_wr && 7'(swm1) < INT_N) begin
      is_mem[swm1[IIW-1:0]] <= il_rd;
    end else if (cmd.decode && iw_en) begin
      is_mem[ci[IIW-1:0]] <= {rx_r, low_r};
    end
    is_rd <= is_mem[ra_s[IIW-1:0]];
  end

  // reply assembly
  logic [7:0]  txb_r [4];
  logic [7:0]  txb_nxt [4];
  logic [2:0]  txn_r, txn_nxt;
  logic [15:0] rval_r, rval_nxt;
  logic [7:0]  bus_cv;
  logic [15:0] bus_iv;

  assign bus_cv = ({1'b0, rx_r[5:0]} < CHAR_N) ? cl_rd : 8'd0;
  assign bus_iv = ({1'b0, rx_r[5:0]} < INT_N) ? il_rd : 16'd0;

  always_comb begin
    for (int j = 0; j < 4; j++) txb_nxt[j] = 8'd0;
    txn_nxt  = 3'd0;
    rval_nxt = 16'd0;
    if (rd_r) begin
      txb_nxt[0] = {1'b0, rx_r[6:0]};
      if (rx_r[6]) begin
        txb_nxt[1] = bus_iv[7:0];
        txb_nxt[2] = bus_iv[15:8];
        txn_nxt    = 3'd3;
      end else begin
        txb_nxt[1] = bus_cv;
        txn_nxt    = 3'd2;
      end
    end
    if (ack_r) begin
      txb_nxt[txn_nxt[1:0]] = ackb_r;
      txn_nxt = txn_nxt + 3'd1;
    end
    if (icmd_r == CMD_READ) begin
      if (isint_r) begin
        if (l_iin) rval_nxt = il_rd;
      end else if (l_cin) begin
        rval_nxt = {8'd0, cl_rd};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gather) begin
      for (int j = 0; j < 4; j++) txb_r[j] <= txb_nxt[j];
      txn_r  <= txn_nxt;
      rval_r <= rval_nxt;
    end
  end

  // result beats
  logic [1:0] k_r;
  logic [2:0] lastk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.gather) begin
      k_r <= '0;
    end else if (cmd.emit_adv) begin
      k_r <= k_r + 2'd1;
    end
  end

  assign lastk              = (txn_r == 3'd0) ? 3'd0 : txn_r - 3'd1;
  assign out_last           = ({1'b0, k_r} == lastk);
  assign out_tx_valid       = ({1'b0, k_r} < txn_r);
  assign out_tx_byte        = out_tx_valid ? txb_r[k_r] : 8'd0;
  assign out_cycle_event    = out_last && evc_r;
  assign out_ready_event    = out_last && evr_r;
  assign out_error_event    = out_last && eve_r;
  assign out_complete_event = out_last && commit_r;
  assign out_read_value     = out_last ? rval_r : 16'd0;
  assign out_read_changed   = out_last && rchg_r;

  assign stat.copy_req   = copy_r;
  assign stat.commit_req = commit_r;
  assign stat.clr_done   = (swp_r == SW_CLR_END);
  assign stat.mv_done    = (swp_r == SW_MV_END);
  assign stat.last_beat  = out_last;

endmodule

// File: rtl/core/multidrop_register_bus_node.sv
// top level of the multidrop register bus node
// depends on mdb_pkg, mdb_in_if, mdb_out_if, mdb_ctrl, mdb_dp
//
//  channel | dir | handshake          | beat
//  --------+-----+--------------------+-----------------------------------------
//  in_ch   | in  | valid / ready      | one item: bus byte, tick, local access
//  out_ch  | out | valid / ready      | one result; last marks end of an item
//  cfg_*   | in  | cfg_we, no wait    | node number (index 0), timeout (index 1)
//
// one item at a time: capture, decode, gather, then one beat per result
// (1 to 4); a new item is taken only after the last beat of the one before
// a node byte of an own frame adds a live-to-shadow copy pass and a frame
// end with zero sum a shadow-to-live commit pass, each a sweep over the
// register memories through their single read port
// after reset a clearing pass over every register address runs with
// in_ch.ready low; configuration writes are taken throughout
// a stalled out_ch holds the current beat and keeps in_ch.ready low
module multidrop_register_bus_node
  import mdb_pkg::*;
#(
  parameter int unsigned CHAR_REGS = 32,
  parameter int unsigned INT_REGS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mdb_in_if.sink               in_ch,
  mdb_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic [15:0] rd_value;

  // sequencer
  mdb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // parser, register store and reply buffer
  mdb_dp #(
    .CHAR_REGS (CHAR_REGS),
    .INT_REGS  (INT_REGS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_cmd             (in_ch.cmd),
    .in_rx_byte         (in_ch.rx_byte),
    .in_local_is_int    (in_ch.local_is_int),
    .in_local_index     (in_ch.local_index),
    .in_local_value     (in_ch.local_value),
    .out_tx_valid       (out_ch.tx_valid),
    .out_tx_byte        (out_ch.tx_byte),
    .out_last           (out_ch.last),
    .out_cycle_event    (out_ch.cycle_event),
    .out_ready_event    (out_ch.ready_event),
    .out_error_event    (out_ch.error_event),
    .out_complete_event (out_ch.complete_event),
    .out_read_value     (rd_value),
    .out_read_changed   (out_ch.read_changed)
  );

  // local read answer as a signed word
  assign out_ch.read_value = $signed(rd_value);

endmodule

// File: rtl/core/mdb_chk.sv
// port-level checks of the bus node, bound to the top level
// depends on multidrop_register_bus_node
module mdb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       last,
  input logic       cycle_event,
  input logic       ready_event,
  input logic       error_event,
  input logic       complete_event,
  input logic       read_changed,
  input logic [15:0] read_value
);

  // a held beat keeps its byte
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last))
    else $error("stalled beat changed");

  // one item in flight: no intake while results are pending
  a_serial: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  // empty beat carries no byte and is the last beat
  a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !tx_valid |-> tx_byte == 8'd0 && last)
    else $error("empty beat carries data or is not last");

  // events and read answer only on the last beat
  a_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !cycle_event && !ready_event && !error_event &&
                           !complete_event && !read_changed && read_value == 16'd0)
    else $error("event on a non-final beat");

endmodule

bind multidrop_register_bus_node mdb_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .tx_valid       (out_ch.tx_valid),
  .tx_byte        (out_ch.tx_byte),
  .last           (out_ch.last),
  .cycle_event    (out_ch.cycle_event),
  .ready_event    (out_ch.ready_event),
  .error_event    (out_ch.error_event),
  .complete_event (out_ch.complete_event),
  .read_changed   (out_ch.read_changed),
  .read_value     (out_ch.read_value)
);

// File: test/multidrop_register_bus_node_tb.sv
`timescale 1ns / 1ps
// testbench of the multidrop register bus node: bus frames, ticks and local accesses
// depends on mdb_pkg, mdb_in_if, mdb_out_if and multidrop_register_bus_node
module multidrop_register_bus_node_tb;
  import mdb_pkg::*;

  localparam int NREGS = 32;

  typedef struct {
    bit        tx_valid;
    bit [7:0]  tx_byte;
    bit        last;
    bit        cycle_ev;
    bit        ready_ev;
    bit        error_ev;
    bit        complete_ev;
    bit [15:0] read_value;
    bit        read_changed;
  } node_result_t;

  // bus node predictor plus queue of expected result beats
  class node_scoreboard;
    node_result_t pending[$];
    int fails, checked, acks, commits;
    bit [7:0]  node_no;
    bit [15:0] tmo;
    phase_t    ph;
    bit [7:0]  rem, sum, cur, low_hold, prev;
    bit        err, sess;
    bit [15:0] idle;
    bit [7:0]  c_live[NREGS], c_sh[NREGS];
    bit [15:0] i_live[NREGS], i_sh[NREGS];
    bit        cc_live[NREGS], cc_sh[NREGS], ic_live[NREGS], ic_sh[NREGS];
    bit [7:0]  txq[$];
    bit        ev_cyc, ev_rdy, ev_err, ev_cmp;

    function new();
      node_no = 0; tmo = TIMEOUT_RST; ph = PH_IDLE;
      rem = 0; sum = 0; cur = 0; low_hold = 0; prev = 0; err = 0; sess = 0; idle = 0;
      foreach (c_live[i]) begin
        c_live[i] = 0; c_sh[i] = 0; i_live[i] = 0; i_sh[i] = 0;
        cc_live[i] = 0; cc_sh[i] = 0; ic_live[i] = 0; ic_sh[i] = 0;
      end
    endfunction

    function void set_cfg(bit [CFG_IDX_W-1:0] idx, bit [15:0] val);
      if (idx == REG_NODE) node_no = val[7:0];
      else tmo = val;
    endfunction

    function void push_tx(bit [7:0] b);
      if (txq.size() < 4) txq.push_back(b);
    endfunction

    function void answer_read(bit [6:0] c);
      bit [5:0] idx;
      idx = c[5:0];
      push_tx({1'b0, c});
      if (c[6]) begin
        push_tx(idx < NREGS ? i_live[idx][7:0] : 8'h00);
        push_tx(idx < NREGS ? i_live[idx][15:8] : 8'h00);
      end else begin
        push_tx(idx < NREGS ? c_live[idx] : 8'h00);
      end
    endfunction

    function void send_ack();
      if (sum == 0 && !err) push_tx(ACK_OK);
      else begin
        ev_err = 1;
        push_tx(ACK_BAD);
      end
      acks++;
      sess = 0;
    endfunction

    // one bus byte through the frame parser; returns 1 on a normal frame end
    function bit take_byte(bit [7:0] b);
      bit done;
      bit [5:0] idx;
      done = 0;
      idx = cur[5:0];
      case (ph)
        PH_IDLE: begin
          if (!sess) err = 0;
          if (prev >= b) ev_cyc = 1;
          prev = b;
          if (b == node_no) begin
            ev_rdy = 1;
            c_sh = c_live; i_sh = i_live; cc_sh = cc_live; ic_sh = ic_live;
            ph = PH_OWN_SUM;
          end else ph = PH_SKIP_SUM;
        end
        PH_SKIP_SUM: ph = PH_SKIP_LEN;
        PH_OWN_SUM: begin
          sum = b + node_no;
          ph = PH_OWN_LEN;
        end
        PH_SKIP_LEN: begin
          rem = b;
          ph = (b == 0) ? PH_IDLE : PH_SKIP_BODY;
        end
        PH_OWN_LEN: begin
          rem = b;
          sum = sum + b;
          if (b == 0) ph = PH_IDLE;
          else begin
            ph = PH_COMMAND;
            sess = 1;
          end
        end
        PH_SKIP_BODY: begin
          rem = rem - 1;
          if (rem == 0) ph = PH_IDLE;
        end
        PH_COMMAND: begin
          cur = b;
          rem = rem - 1;
          sum = sum + b;
          if (b[7]) begin
            answer_read(b[6:0]);
            if (rem == 0) begin
              ph = PH_IDLE;
              done = 1;
            end
          end else if (rem == 0) begin
            err = 1;
            ph = PH_IDLE;
          end else ph = b[6] ? PH_INT_LOW : PH_CHAR_DATA;
        end
        PH_CHAR_DATA: begin
          if (idx < NREGS) begin
            c_sh[idx] = b; cc_sh[idx] = 1; sum = sum + b;
          end else err = 1;
          rem = rem - 1;
          if (rem == 0) begin
            ph = PH_IDLE;
            done = 1;
          end else ph = PH_COMMAND;
        end
        PH_INT_LOW: begin
          if (rem <= 1) begin
            rem = 0; err = 1; ph = PH_IDLE;
          end else begin
            low_hold = b;
            if (idx < NREGS) sum = sum + b;
            rem = rem - 1;
            ph = PH_INT_HIGH;
          end
        end
        PH_INT_HIGH: begin
          if (idx < NREGS) begin
            sum = sum + b;
            i_sh[idx] = {b, low_hold};
            ic_sh[idx] = 1;
          end else err = 1;
          rem = rem - 1;
          if (rem == 0) begin
            ph = PH_IDLE;
            done = 1;
          end else ph = PH_COMMAND;
        end
        default: ph = PH_IDLE;
      endcase
      return done;
    endfunction

    // work out the result beats of one accepted input beat
    function void note_input(bit [1:0] cmd, bit [7:0] rx, bit is_int, bit [5:0] lidx,
                             bit [15:0] lval);
      bit done;
      bit [15:0] rd_val;
      bit rd_chg;
      int n;
      node_result_t r;
      txq.delete();
      ev_cyc = 0; ev_rdy = 0; ev_err = 0; ev_cmp = 0;
      rd_val = 0; rd_chg = 0;
      case (cmd)
        CMD_BYTE: begin
          idle = 0;
          done = take_byte(rx);
          if (sess && ph == PH_IDLE) send_ack();
          if (done && sum == 0) begin
            c_live = c_sh; i_live = i_sh; cc_live = cc_sh; ic_live = ic_sh;
            ev_cmp = 1;
            commits++;
          end
        end
        CMD_TICK: begin
          if (32'(idle) + 1 > 32'(tmo)) begin
            ph = PH_IDLE;
            if (sess) send_ack();
          end
          if (idle != 16'hFFFF) idle = idle + 1;
        end
        CMD_WRITE: begin
          if (lidx < NREGS) begin
            if (is_int) i_live[lidx] = lval;
            else c_live[lidx] = lval[7:0];
          end
        end
        default: begin
          if (lidx < NREGS) begin
            if (is_int) begin
              rd_val = i_live[lidx]; rd_chg = ic_live[lidx]; ic_live[lidx] = 0;
            end else begin
              rd_val = {8'h00, c_live[lidx]}; rd_chg = cc_live[lidx]; cc_live[lidx] = 0;
            end
          end
        end
      endcase
      n = (txq.size() > 0) ? txq.size() : 1;
      for (int k = 0; k < n; k++) begin
        r.last         = (k == n - 1);
        r.tx_valid     = (k < txq.size());
        r.tx_byte      = r.tx_valid ? txq[k] : 8'h00;
        r.cycle_ev     = r.last && ev_cyc;
        r.ready_ev     = r.last && ev_rdy;
        r.error_ev     = r.last && ev_err;
        r.complete_ev  = r.last && ev_cmp;
        r.read_value   = r.last ? rd_val : 16'h0000;
        r.read_changed = r.last && rd_chg;
        pending.push_back(r);
      end
    endfunction

    function void cmp_field(string name, int unsigned e, int unsigned g);
      if (e != g) begin
        $error("%s mismatch: expected %0h, got %0h", name, e, g);
        fails++;
      end
    endfunction

    function void check_result(node_result_t got);
      node_result_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
        return;
      end
      e = pending.pop_front();
      cmp_field("tx_valid", e.tx_valid, got.tx_valid);
      cmp_field("tx_byte", e.tx_byte, got.tx_byte);
      cmp_field("last", e.last, got.last);
      cmp_field("cycle_event", e.cycle_ev, got.cycle_ev);
      cmp_field("ready_event", e.ready_ev, got.ready_ev);
      cmp_field("error_event", e.error_ev, got.error_ev);
      cmp_field("complete_event", e.complete_ev, got.complete_ev);
      cmp_field("read_value", e.read_value, got.read_value);
      cmp_field("read_changed", e.read_changed, got.read_changed);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  mdb_in_if  in_ch();
  mdb_out_if out_ch();

  multidrop_register_bus_node u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  node_scoreboard sb = new();
  int  items_sent;
  bit  calm;        // set for the last part of the run: no idling on either side
  int  gap_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // overall limit: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("multidrop_register_bus_node_tb: FAIL");
    $finish;
  end

  // result side: random stall bursts, every accepted beat goes to the scoreboard
  initial begin
    int stall;
    node_result_t got;
    stall = 0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.tx_valid     = out_ch.tx_valid;
        got.tx_byte      = out_ch.tx_byte;
        got.last         = out_ch.last;
        got.cycle_ev     = out_ch.cycle_event;
        got.ready_ev     = out_ch.ready_event;
        got.error_ev     = out_ch.error_event;
        got.complete_ev  = out_ch.complete_event;
        got.read_value   = out_ch.read_value;
        got.read_changed = out_ch.read_changed;
        sb.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one input beat; returns on the edge that accepts it
  task automatic send_item(bit [1:0] cmd, bit [7:0] rx, bit is_int, bit [5:0] lidx,
                           bit [15:0] lval);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.rx_byte      <= rx;
    in_ch.local_is_int <= is_int;
    in_ch.local_index  <= lidx;
    in_ch.local_value  <= lval;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, rx, is_int, lidx, lval);
    items_sent++;
  endtask

  task automatic send_byte(bit [7:0] b);
    send_item(CMD_BYTE, b, 1'($urandom), 6'($urandom), 16'($urandom));
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom), 1'($urandom), 6'($urandom), 16'($urandom));
  endtask

  // sender holds off until every expected beat is in, then lets the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_cfg(bit [CFG_IDX_W-1:0] idx, bit [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_cfg(idx, val);
  endtask

  // sum of the body bytes the node counts: data of out-of-range writes is left out
  function automatic bit [7:0] body_sum(bit [7:0] body[$]);
    bit [7:0] s;
    int i;
    s = 0;
    i = 0;
    while (i < body.size()) begin
      s += body[i];
      if (body[i][7]) i += 1;
      else if (body[i][6]) begin
        if (body[i][5:0] < NREGS) begin
          if (i + 1 < body.size()) s += body[i + 1];
          if (i + 2 < body.size()) s += body[i + 2];
        end
        i += 3;
      end else begin
        if (body[i][5:0] < NREGS && i + 1 < body.size()) s += body[i + 1];
        i += 2;
      end
    end
    return s;
  endfunction

  // node, checksum, length, body; checksum made good unless bad_sum
  task automatic send_frame(bit [7:0] nd, bit [7:0] body[$], bit bad_sum, int cut = -1);
    bit [7:0] chk;
    bit [7:0] len;
    len = 8'(body.size());
    chk = 8'h00 - (sb.node_no + len + body_sum(body));
    if (bad_sum) chk ^= 8'(1 << $urandom_range(0, 7));
    send_byte(nd);
    send_byte(chk);
    send_byte(len);
    foreach (body[i]) begin
      if (cut >= 0 && i >= cut) break;
      send_byte(body[i]);
    end
  endtask

  function automatic bit [5:0] pick_index();
    return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(32, 63)) : 6'($urandom_range(0, 31));
  endfunction

  // well-formed command list: reads and char/int writes with random content
  function automatic void make_body(ref bit [7:0] body[$]);
    body.delete();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: body.push_back({2'b10, pick_index()});
        1: body.push_back({2'b11, pick_index()});
        2: begin
          body.push_back({2'b00, pick_index()});
          body.push_back(8'($urandom));
        end
        default: begin
          body.push_back({2'b01, pick_index()});
          body.push_back(8'($urandom));
          body.push_back(8'($urandom));
        end
      endcase
    end
  endfunction

  // random traffic until the item count reaches the target
  task automatic run_random(int target);
    bit [7:0] body[$];
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        make_body(body);
        send_frame(sb.node_no, body, $urandom_range(0, 9) == 0);
      end else if (pick < 67) begin
        body.delete();
        repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
        send_frame(sb.node_no + 8'($urandom_range(1, 255)), body, 1'b0);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 3)) send_tick();
      end else if (pick < 90) begin
        send_item($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                  1'($urandom), 6'($urandom), 16'($urandom));
      end else if (pick < 95 && sb.tmo <= 8) begin
        // frame cut short, then ticks until the idle timeout closes it
        make_body(body);
        send_frame(sb.node_no, body, 1'b0, $urandom_range(0, body.size() - 1));
        repeat (sb.tmo + 1) send_tick();
      end else begin
        // broken command lists: zero length, trailing write, short int write
        case ($urandom_range(0, 2))
          0: body = {};
          1: body = {{2'b00, pick_index()}};
          default: body = {{2'b01, pick_index()}, 8'($urandom)};
        endcase
        send_frame(sb.node_no, body, 1'b0);
      end
    end
  endtask

  initial begin
    bit [7:0] body[$];
    items_sent = 0;
    calm = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_NODE;
    cfg_wdata <= 16'h0000;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_BYTE;
    in_ch.rx_byte      <= 8'h00;
    in_ch.local_is_int <= 1'b0;
    in_ch.local_index  <= 6'd0;
    in_ch.local_value  <= 16'h0000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: local accesses, a good frame, and the odd frame shapes
    write_cfg(REG_NODE, 16'd5);
    write_cfg(REG_TIMEOUT, 16'd500);
    send_item(CMD_WRITE, 8'h00, 1'b1, 6'd1, 16'h8000);
    send_item(CMD_READ, 8'hFF, 1'b1, 6'd1, 16'h0000);
    send_item(CMD_READ, 8'h00, 1'b0, 6'd40, 16'hFFFF);
    send_item(CMD_WRITE, 8'h00, 1'b0, 6'd63, 16'h7FFF);
    send_item(CMD_WRITE, 8'h00, 1'b0, 6'd0, 16'hFFFF);
    body = {8'h00, 8'hA5, 8'h41, 8'h34, 8'h12, 8'h80, 8'hC1};
    send_frame(8'd5, body, 1'b0);
    send_item(CMD_READ, 8'h00, 1'b0, 6'd0, 16'h0000);
    body = {};
    send_frame(8'd5, body, 1'b0);               // zero length
    body = {8'h02};
    send_frame(8'd5, body, 1'b0);               // write as last body byte
    body = {8'h41, 8'h10};
    send_frame(8'd5, body, 1'b0);               // int write with one byte left
    body = {8'h25, 8'h11, 8'hFF};
    send_frame(8'd5, body, 1'b0);               // out-of-range write and read
    body = {8'h01, 8'h02};
    send_frame(8'd9, body, 1'b0);               // foreign frame
    send_frame(8'd3, body, 1'b0);               // node went down: new bus cycle
    body = {8'h81};
    send_frame(8'd5, body, 1'b1);               // bad checksum

    // random phases across node and timeout settings, extremes included
    drain();
    write_cfg(REG_NODE, 16'd0);
    write_cfg(REG_TIMEOUT, 16'd1);
    run_random(120);
    drain();
    write_cfg(REG_NODE, 16'd255);
    write_cfg(REG_TIMEOUT, 16'd65535);
    run_random(220);
    drain();
    write_cfg(REG_NODE, 16'($urandom_range(1, 254)));
    write_cfg(REG_TIMEOUT, 16'($urandom_range(2, 6)));
    run_random(330);
    drain();
    calm = 1;
    write_cfg(REG_NODE, 16'($urandom_range(0, 255)));
    write_cfg(REG_TIMEOUT, 16'd3);
    run_random(420);

    drain();
    if (sb.pending.size() != 0) begin
      $error("%0d expected beats never arrived", sb.pending.size());
      sb.fails++;
    end
    $display("run: %0d input beats, %0d result beats checked, %0d acks, %0d commits",
             items_sent, sb.checked, sb.acks, sb.commits);
    if (sb.fails == 0) begin
      $display("multidrop_register_bus_node_tb: PASS");
    end else begin
      $display("multidrop_register_bus_node_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: multidrop_register_bus_node.f
rtl/core/mdb_pkg.sv
rtl/core/mdb_in_if.sv
rtl/core/mdb_out_if.sv
rtl/core/mdb_ctrl.sv
rtl/core/mdb_dp.sv
rtl/core/multidrop_register_bus_node.sv
rtl/core/mdb_chk.sv
test/multidrop_register_bus_node_tb.sv
